[hw/rtl/dcd_pkg.sv]
// ----------------------------------------------------------------------------
// dcd_pkg
// Shared constants and types of the debounce and chatter detector.
// ----------------------------------------------------------------------------
package dcd_pkg;

   localparam int HISTORY_DEPTH = 8;
   localparam int CNT_W         = $clog2(HISTORY_DEPTH + 1);
   localparam int THR_W         = 3;
   localparam int CMP_W         = (CNT_W > THR_W) ? CNT_W : THR_W;
   localparam int TIME_W        = 32;
   localparam int WIN_W         = 20;
   localparam int DLEN_W        = 4;
   localparam int TALLY_W       = 8;
   localparam int CSR_IDX_W     = 2;
   localparam int CSR_DATA_W    = 20;

   localparam logic [CSR_IDX_W-1:0] CSR_DEBOUNCE_LENGTH   = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_CHATTER_THRESHOLD = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_WINDOW_MS         = 2'd2;

   localparam logic [DLEN_W-1:0] DLEN_RESET = 4'd3;
   localparam logic [THR_W-1:0]  THR_RESET  = 3'd5;
   localparam logic [WIN_W-1:0]  WIN_RESET  = 20'd5000;

   typedef struct packed {
      logic shift;
      logic capture;
   } cell_ctl_type;

endpackage

[hw/rtl/dcd_if.sv]
// ----------------------------------------------------------------------------
// dcd_if
// Valid/ready channels of the debounce and chatter detector.
// ----------------------------------------------------------------------------
interface dcd_req_if;
   import dcd_pkg::*;
   logic              valid;
   logic              ready;
   logic              raw_sample;
   logic [TIME_W-1:0] time_ms;
   modport source (output valid, output raw_sample, output time_ms, input ready);
   modport sink   (input valid, input raw_sample, input time_ms, output ready);
endinterface

interface dcd_rsp_if;
   import dcd_pkg::*;
   logic               valid;
   logic               ready;
   logic               validated_level;
   logic [DLEN_W-1:0]  agree_count;
   logic               chatter_flag;
   logic [TALLY_W-1:0] chatter_events;
   modport source (output valid, output validated_level, output agree_count,
                   output chatter_flag, output chatter_events, input ready);
   modport sink   (input valid, input validated_level, input agree_count,
                   input chatter_flag, input chatter_events, output ready);
endinterface

interface dcd_csr_if;
   import dcd_pkg::*;
   logic                  valid;
   logic                  ready;
   logic [CSR_IDX_W-1:0]  index;
   logic [CSR_DATA_W-1:0] data;
   modport source (output valid, output index, output data, input ready);
   modport sink   (input valid, input index, input data, output ready);
endinterface

[hw/rtl/dcd_cell.sv]
// ----------------------------------------------------------------------------
// dcd_cell
// One history cell: holds an edge timestamp and tests its age against the window.
// ----------------------------------------------------------------------------
module dcd_cell (
   input  logic                        clock,
   input  logic                        reset,
   input  dcd_pkg::cell_ctl_type       ctl,
   input  logic [dcd_pkg::TIME_W-1:0]  now,
   input  logic [dcd_pkg::WIN_W-1:0]   window,
   input  logic [dcd_pkg::TIME_W-1:0]  prev_time,
   input  logic                        prev_valid,
   output logic [dcd_pkg::TIME_W-1:0]  time_out,
   output logic                        valid_out,
   output logic                        hit
);
   import dcd_pkg::*;

   logic [TIME_W-1:0] time_ff;
   logic              valid_ff;
   logic              hit_ff;
   logic [TIME_W-1:0] age;
   logic              hit_in;

   assign age    = now - time_ff;
   assign hit_in = valid_ff && (age <= TIME_W'(window));

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         hit_ff   <= 1'b0;
      end else begin
         if (ctl.shift) begin
            valid_ff <= prev_valid;
         end
         if (ctl.capture) begin
            hit_ff <= hit_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.shift) begin
         time_ff <= prev_time;
      end
   end

   assign time_out  = time_ff;
   assign valid_out = valid_ff;
   assign hit       = hit_ff;

endmodule

[hw/rtl/dcd_chain.sv]
// ----------------------------------------------------------------------------
// dcd_chain
// Row of history cells, newest edge at the head, plus the count of recent edges.
// ----------------------------------------------------------------------------
module dcd_chain (
   input  logic                        clock,
   input  logic                        reset,
   input  dcd_pkg::cell_ctl_type       ctl,
   input  logic [dcd_pkg::TIME_W-1:0]  now,
   input  logic [dcd_pkg::WIN_W-1:0]   window,
   output logic [dcd_pkg::CNT_W-1:0]   hit_count
);
   import dcd_pkg::*;

   logic [TIME_W-1:0]        time_link [HISTORY_DEPTH+1];
   logic [HISTORY_DEPTH:0]   valid_link;
   logic [HISTORY_DEPTH-1:0] hits;
   logic [CNT_W-1:0]         sum;

   assign time_link[0]  = now;
   assign valid_link[0] = 1'b1;

   for (genvar i = 0; i < HISTORY_DEPTH; i++) begin : g_cell
      dcd_cell u_cell (
         .clock      (clock),
         .reset      (reset),
         .ctl        (ctl),
         .now        (now),
         .window     (window),
         .prev_time  (time_link[i]),
         .prev_valid (valid_link[i]),
         .time_out   (time_link[i+1]),
         .valid_out  (valid_link[i+1]),
         .hit        (hits[i])
      );
   end

   // last cell falls out of the ring when the new edge comes in
   always_comb begin
      sum = '0;
      for (int i = 0; i < HISTORY_DEPTH - 1; i++) begin
         sum = sum + CNT_W'(hits[i]);
      end
   end

   assign hit_count = sum;

endmodule

[hw/rtl/debounce_and_chatter_detector.sv]
// ----------------------------------------------------------------------------
// debounce_and_chatter_detector
// Counter debouncer with sliding-window chatter detection.
// ----------------------------------------------------------------------------
// Each item on req_ch is one sample of a binary signal with its millisecond
// timestamp; each sample yields exactly one item on rsp_ch with the debounced
// level, the agreement count, the chatter flag and the chatter event count.
// csr_ch writes debounce_length (0), chatter_threshold (1) and window_ms (2)
// and is always ready; other indexes are dropped. Write it only while idle.
// A sample goes through accept and debounce update, a parallel age compare
// in every history cell (one 32-bit subtract and compare per cell) with the
// shift of the cell row on a raw edge, then the count against the threshold
// and the load of the output register. req_ch.ready is high only between
// items, so a new item is taken only after the last has left its final step.
// When rsp_ch stalls the result waits in the output register and a new
// sample is still accepted; the block then holds in its last step until the
// register is taken. Reset empties the history, clears the debounce and
// chatter state and restores the register defaults.
// ----------------------------------------------------------------------------
module debounce_and_chatter_detector (
   input  logic      clock,
   input  logic      reset,
   dcd_req_if.sink   req_ch,
   dcd_rsp_if.source rsp_ch,
   dcd_csr_if.sink   csr_ch
);
   import dcd_pkg::*;

   typedef enum logic [1:0] {S_IDLE, S_CMP, S_SUM} state_type;

   state_type          state_ff, state_in;
   logic [DLEN_W-1:0]  dlen_ff, dlen_in;
   logic [THR_W-1:0]   thr_ff, thr_in;
   logic [WIN_W-1:0]   win_ff, win_in;
   logic               pending_ff, pending_in;
   logic [DLEN_W-1:0]  agree_ff, agree_in;
   logic               held_ff, held_in;
   logic               prev_raw_ff, prev_raw_in;
   logic               edge_ff, edge_in;
   logic [TIME_W-1:0]  now_ff, now_in;
   logic               flag_ff, flag_in;
   logic [TALLY_W-1:0] tally_ff, tally_in;
   logic               rsp_valid_ff, rsp_valid_in;
   logic               out_level_ff, out_level_in;
   logic [DLEN_W-1:0]  out_agree_ff, out_agree_in;
   logic               out_flag_ff, out_flag_in;
   logic [TALLY_W-1:0] out_tally_ff, out_tally_in;

   logic               accept;
   logic               csr_write;
   logic               out_free;
   logic               over;
   logic [CNT_W-1:0]   hit_count;
   logic [CMP_W-1:0]   recent;
   cell_ctl_type       cell_ctl;

   assign accept        = req_ch.valid && req_ch.ready;
   assign csr_write     = csr_ch.valid && csr_ch.ready;
   assign req_ch.ready  = (state_ff == S_IDLE);
   assign csr_ch.ready  = 1'b1;
   assign out_free      = !rsp_valid_ff || rsp_ch.ready;

   assign cell_ctl.shift   = (state_ff == S_CMP) && edge_ff;
   assign cell_ctl.capture = (state_ff == S_CMP);

   dcd_chain u_chain (
      .clock     (clock),
      .reset     (reset),
      .ctl       (cell_ctl),
      .now       (now_ff),
      .window    (win_ff),
      .hit_count (hit_count)
   );

   // newest edge always counts
   assign recent = CMP_W'(hit_count) + CMP_W'(1);
   assign over   = recent > CMP_W'(thr_ff);

   always_comb begin
      state_in     = state_ff;
      dlen_in      = dlen_ff;
      thr_in       = thr_ff;
      win_in       = win_ff;
      pending_in   = pending_ff;
      agree_in     = agree_ff;
      held_in      = held_ff;
      prev_raw_in  = prev_raw_ff;
      edge_in      = edge_ff;
      now_in       = now_ff;
      flag_in      = flag_ff;
      tally_in     = tally_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ch.ready;
      out_level_in = out_level_ff;
      out_agree_in = out_agree_ff;
      out_flag_in  = out_flag_ff;
      out_tally_in = out_tally_ff;

      if (csr_write) begin
         unique case (csr_ch.index)
            CSR_DEBOUNCE_LENGTH:   dlen_in = csr_ch.data[DLEN_W-1:0];
            CSR_CHATTER_THRESHOLD: thr_in  = csr_ch.data[THR_W-1:0];
            CSR_WINDOW_MS:         win_in  = csr_ch.data[WIN_W-1:0];
            default: ;
         endcase
      end

      unique case (state_ff)
         S_IDLE: begin
            if (accept) begin
               if (req_ch.raw_sample == pending_ff) begin
                  if (agree_ff < dlen_ff) begin
                     agree_in = agree_ff + DLEN_W'(1);
                  end
               end else begin
                  pending_in = req_ch.raw_sample;
                  agree_in   = DLEN_W'(1);
               end
               if (agree_in >= dlen_ff) begin
                  held_in = pending_in;
               end
               edge_in     = req_ch.raw_sample != prev_raw_ff;
               prev_raw_in = req_ch.raw_sample;
               now_in      = req_ch.time_ms;
               state_in    = S_CMP;
            end
         end
         S_CMP: begin
            state_in = S_SUM;
         end
         S_SUM: begin
            if (out_free) begin
               if (edge_ff) begin
                  flag_in = over;
                  if (over && !flag_ff) begin
                     tally_in = tally_ff + TALLY_W'(1);
                  end
               end
               rsp_valid_in = 1'b1;
               out_level_in = held_ff;
               out_agree_in = agree_ff;
               out_flag_in  = flag_in;
               out_tally_in = tally_in;
               state_in     = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         dlen_ff      <= DLEN_RESET;
         thr_ff       <= THR_RESET;
         win_ff       <= WIN_RESET;
         pending_ff   <= 1'b0;
         agree_ff     <= '0;
         held_ff      <= 1'b0;
         prev_raw_ff  <= 1'b0;
         edge_ff      <= 1'b0;
         flag_ff      <= 1'b0;
         tally_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         dlen_ff      <= dlen_in;
         thr_ff       <= thr_in;
         win_ff       <= win_in;
         pending_ff   <= pending_in;
         agree_ff     <= agree_in;
         held_ff      <= held_in;
         prev_raw_ff  <= prev_raw_in;
         edge_ff      <= edge_in;
         flag_ff      <= flag_in;
         tally_ff     <= tally_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      now_ff       <= now_in;
      out_level_ff <= out_level_in;
      out_agree_ff <= out_agree_in;
      out_flag_ff  <= out_flag_in;
      out_tally_ff <= out_tally_in;
   end

   assign rsp_ch.valid           = rsp_valid_ff;
   assign rsp_ch.validated_level = out_level_ff;
   assign rsp_ch.agree_count     = out_agree_ff;
   assign rsp_ch.chatter_flag    = out_flag_ff;
   assign rsp_ch.chatter_events  = out_tally_ff;

   // one item in flight
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      accept |=> !req_ch.ready)
      else $error("sample accepted while another is in flight");

   // event count moves only with a rising flag
   a_tally_on_rise: assert property (@(posedge clock) disable iff (reset)
      (tally_ff != $past(tally_ff)) |-> (flag_ff && !$past(flag_ff)))
      else $error("chatter event count changed without a rising flag");

   // a new result only comes from the final step
   a_rsp_from_sum: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !$past(rsp_valid_ff)) |-> $past(state_ff == S_SUM))
      else $error("result raised outside the final step");

   // cells shift only on a raw edge
   a_shift_on_edge: assert property (@(posedge clock) disable iff (reset)
      cell_ctl.shift |-> (edge_ff && state_ff == S_CMP))
      else $error("history shifted without a raw edge");

endmodule

[test/debounce_and_chatter_detector_tb.sv]
// ----------------------------------------------------------------------------
// debounce_and_chatter_detector_tb
// Self-checking testbench for the debouncer with chatter detection.
// ----------------------------------------------------------------------------
// Samples go in on the request channel and a scoreboard keeps its own copy of
// the debounce counter, the edge history ring and the chatter state. Every
// result is checked field by field against the oldest prediction. A short
// directed run covers wrap-around timestamps, window edges, zero length and
// zero threshold. Several register settings then follow, each with random
// bursts of chatter, stable runs and noise. Both channels stall at random.
// ----------------------------------------------------------------------------
module debounce_and_chatter_detector_tb;
   timeunit 1ns;
   timeprecision 1ps;
   import dcd_pkg::*;

   localparam logic [CSR_IDX_W-1:0] CSR_UNUSED_INDEX = 2'd3;
   localparam int NUM_PHASES = 8;
   localparam int ITEMS_PER_PHASE = 200;

   typedef struct packed {
      logic               level;
      logic [DLEN_W-1:0]  count;
      logic               flag;
      logic [TALLY_W-1:0] events;
   } dcd_result_type;

   class dcd_scoreboard_type;
      logic [DLEN_W-1:0]  debounce_len;
      logic [THR_W-1:0]   threshold;
      logic [WIN_W-1:0]   window;
      logic               pending_lvl;
      logic [DLEN_W-1:0]  agree;
      logic               validated;
      logic               last_raw;
      logic [TIME_W-1:0]  edge_ring [HISTORY_DEPTH];
      int                 head;
      int                 fill;
      logic               flag;
      logic [TALLY_W-1:0] tally;
      dcd_result_type     expected_q [$];
      int                 mismatches;
      int                 checked;
      int                 flagged;

      function new();
         debounce_len = DLEN_RESET;
         threshold    = THR_RESET;
         window       = WIN_RESET;
         pending_lvl  = 1'b0;
         agree        = '0;
         validated    = 1'b0;
         last_raw     = 1'b0;
         head         = 0;
         fill         = 0;
         flag         = 1'b0;
         tally        = '0;
         mismatches   = 0;
         checked      = 0;
         flagged      = 0;
      endfunction

      function void write_reg(logic [CSR_IDX_W-1:0] idx, logic [CSR_DATA_W-1:0] data);
         case (idx)
            CSR_DEBOUNCE_LENGTH:   debounce_len = data[DLEN_W-1:0];
            CSR_CHATTER_THRESHOLD: threshold    = data[THR_W-1:0];
            CSR_WINDOW_MS:         window       = data[WIN_W-1:0];
            default: ;
         endcase
      endfunction

      function void add_sample(logic raw, logic [TIME_W-1:0] stamp);
         int                recent;
         int                slot;
         logic [TIME_W-1:0] age;
         if (raw == pending_lvl) begin
            if (agree < debounce_len) agree = agree + 1'b1;
         end else begin
            pending_lvl = raw;
            agree       = DLEN_W'(1);
         end
         if (agree >= debounce_len) validated = pending_lvl;
         if (raw != last_raw) begin
            edge_ring[head] = stamp;
            head = (head + 1) % HISTORY_DEPTH;
            if (fill < HISTORY_DEPTH) fill++;
            recent = 0;
            for (int i = 0; i < fill; i++) begin
               slot = (head + HISTORY_DEPTH - fill + i) % HISTORY_DEPTH;
               age  = stamp - edge_ring[slot];
               if (age <= TIME_W'(window)) recent++;
            end
            if (recent > int'(threshold)) begin
               if (!flag) tally = tally + 1'b1;
               flag = 1'b1;
            end else begin
               flag = 1'b0;
            end
            last_raw = raw;
         end
         expected_q.push_back(dcd_result_type'{validated, agree, flag, tally});
      endfunction

      function void check_output(dcd_result_type got);
         dcd_result_type want;
         if (expected_q.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("%0t: unexpected result lvl=%0b cnt=%0d flag=%0b ev=%0d", $realtime,
                        got.level, got.count, got.flag, got.events);
            return;
         end
         want = expected_q.pop_front();
         checked++;
         if (got.flag) flagged++;
         if (got.level !== want.level || got.count !== want.count ||
             got.flag !== want.flag || got.events !== want.events) begin
            mismatches++;
            if (mismatches <= 10)
               $display("%0t: exp %0b/%0d/%0b/%0d got %0b/%0d/%0b/%0d",
                        $realtime, want.level, want.count, want.flag, want.events,
                        got.level, got.count, got.flag, got.events);
         end
      endfunction
   endclass

   logic               clock;
   logic               reset;
   bit                 quiet;
   int                 rsp_hold;
   int unsigned        cur_win;
   int                 settings_used;
   int                 sent;
   logic               stim_level;
   logic [TIME_W-1:0]  now_ms;
   dcd_scoreboard_type sb;

   dcd_req_if req_ch ();
   dcd_rsp_if rsp_ch ();
   dcd_csr_if csr_ch ();

   debounce_and_chatter_detector DUT (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch),
      .csr_ch (csr_ch)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   initial begin
      #5_000_000;
      $display("TEST FAILED");
      $finish;
   end

   task automatic send_sample(logic raw, logic [TIME_W-1:0] stamp);
      req_ch.valid      = 1'b1;
      req_ch.raw_sample = raw;
      req_ch.time_ms    = stamp;
      do @(posedge clock); while (!req_ch.ready);
      sb.add_sample(raw, stamp);
      sent++;
      @(negedge clock);
      if (!quiet && $urandom_range(0, 4) == 0) begin
         req_ch.valid = 1'b0;
         repeat ($urandom_range(1, 14)) @(negedge clock);
      end
   endtask

   task automatic write_csr(logic [CSR_IDX_W-1:0] idx, logic [CSR_DATA_W-1:0] data);
      csr_ch.valid = 1'b1;
      csr_ch.index = idx;
      csr_ch.data  = data;
      do @(posedge clock); while (!csr_ch.ready);
      sb.write_reg(idx, data);
      @(negedge clock);
      csr_ch.valid = 1'b0;
   endtask

   task automatic wait_idle();
      req_ch.valid = 1'b0;
      while (sb.expected_q.size() != 0) @(negedge clock);
      repeat (4) @(negedge clock);
   endtask

   task automatic apply_settings(int dlen, int thr, int win);
      logic [CSR_DATA_W-1:0] data;
      wait_idle();
      data = CSR_DATA_W'($urandom);
      data[DLEN_W-1:0] = DLEN_W'(dlen);
      write_csr(CSR_DEBOUNCE_LENGTH, data);
      data = CSR_DATA_W'($urandom);
      data[THR_W-1:0] = THR_W'(thr);
      write_csr(CSR_CHATTER_THRESHOLD, data);
      write_csr(CSR_WINDOW_MS, CSR_DATA_W'(win));
      cur_win = win;
      settings_used++;
   endtask

   task automatic run_random(int n);
      int          done;
      int          kind;
      int          len;
      int unsigned span;
      done = 0;
      while (done < n) begin
         kind = $urandom_range(0, 99);
         if (kind < 55) begin
            // burst of edges spaced against the window
            len  = $urandom_range(3, 12);
            span = cur_win / 4 + 2;
            for (int k = 0; k < len; k++) begin
               if ($urandom_range(0, 3) != 0) stim_level = ~stim_level;
               now_ms = now_ms + $urandom_range(0, span);
               send_sample(stim_level, now_ms);
            end
         end else if (kind < 85) begin
            // stable run of up to 20 samples at one level
            len        = $urandom_range(1, 20);
            stim_level = 1'($urandom_range(0, 1));
            for (int k = 0; k < len; k++) begin
               now_ms = now_ms + $urandom_range(1, 64);
               send_sample(stim_level, now_ms);
            end
         end else begin
            len = $urandom_range(1, 4);
            for (int k = 0; k < len; k++) begin
               stim_level = 1'($urandom_range(0, 1));
               case ($urandom_range(0, 2))
                  0: now_ms = $urandom;
                  1: now_ms = now_ms + $urandom_range(0, 2 * cur_win + 2);
                  default: now_ms = 32'hFFFF_FFFF - $urandom_range(0, 50);
               endcase
               send_sample(stim_level, now_ms);
            end
         end
         done += len;
      end
   endtask

   // result side ready with random stalls and a long hold on request
   initial begin : rsp_driver
      int stall;
      stall = 0;
      rsp_ch.ready = 1'b0;
      forever begin
         @(negedge clock);
         if (rsp_hold > 0) begin
            rsp_ch.ready = 1'b0;
            rsp_hold--;
         end else if (stall > 0) begin
            rsp_ch.ready = 1'b0;
            stall--;
         end else if (!quiet && $urandom_range(0, 5) == 0) begin
            rsp_ch.ready = 1'b0;
            stall = $urandom_range(1, 14) - 1;
         end else begin
            rsp_ch.ready = 1'b1;
         end
      end
   end

   initial begin
      forever begin
         @(posedge clock);
         if (!reset && rsp_ch.valid === 1'b1 && rsp_ch.ready)
            sb.check_output(dcd_result_type'{rsp_ch.validated_level, rsp_ch.agree_count,
                                             rsp_ch.chatter_flag, rsp_ch.chatter_events});
      end
   end

   initial begin
      int dlen;
      int thr;
      int win;
      reset             = 1'b1;
      quiet             = 1'b0;
      rsp_hold          = 0;
      cur_win           = WIN_RESET;
      settings_used     = 1;
      sent              = 0;
      stim_level        = 1'b0;
      now_ms            = '0;
      req_ch.valid      = 1'b0;
      req_ch.raw_sample = 1'b0;
      req_ch.time_ms    = '0;
      csr_ch.valid      = 1'b0;
      csr_ch.index      = CSR_DEBOUNCE_LENGTH;
      csr_ch.data       = '0;
      sb = new();
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // reset settings: chatter burst, stable run, timestamp wrap
      send_sample(1'b0, 32'h0000_0000);
      send_sample(1'b1, 32'd1);
      send_sample(1'b0, 32'd2);
      send_sample(1'b1, 32'd3);
      send_sample(1'b0, 32'd4);
      send_sample(1'b1, 32'd5);
      send_sample(1'b0, 32'd6);
      send_sample(1'b1, 32'd7);
      send_sample(1'b1, 32'd8);
      send_sample(1'b1, 32'd9);
      send_sample(1'b1, 32'd10);
      send_sample(1'b0, 32'hFFFF_FFFF);
      send_sample(1'b1, 32'd5);
      send_sample(1'b1, 32'd6);

      // zero length and zero threshold
      apply_settings(0, 0, 0);
      write_csr(CSR_UNUSED_INDEX, CSR_DATA_W'($urandom));
      send_sample(1'b0, 32'd100);
      send_sample(1'b0, 32'd100);
      send_sample(1'b1, 32'd100);
      send_sample(1'b1, 32'd101);
      send_sample(1'b0, 32'd101);

      // age exactly at and just past the widest window
      apply_settings(15, 1, 1048575);
      send_sample(1'b1, 32'h1000_0000);
      send_sample(1'b0, 32'h100F_FFFF);
      send_sample(1'b1, 32'h1010_0000);
      send_sample(1'b0, 32'h1020_0000);
      stim_level = 1'b0;
      now_ms     = 32'h1020_0000;

      for (int p = 0; p < NUM_PHASES; p++) begin
         case (p)
            0: begin dlen = 3;  thr = 5; win = 5000;    end
            1: begin dlen = 0;  thr = 0; win = 0;       end
            2: begin dlen = 15; thr = 7; win = 1048575; end
            3: begin dlen = 1;  thr = 1; win = 20;      end
            5: begin dlen = 2;  thr = 3; win = 100;     end
            default: begin
               dlen = $urandom_range(0, 15);
               thr  = $urandom_range(0, 7);
               case ($urandom_range(0, 2))
                  0: win = $urandom_range(0, 64);
                  1: win = $urandom_range(0, 20000);
                  default: win = $urandom_range(0, 1048575);
               endcase
            end
         endcase
         apply_settings(dlen, thr, win);
         if (p == NUM_PHASES - 1) quiet = 1'b1;
         if (p == 2) rsp_hold = 300;
         if (p == 4) begin
            run_random(ITEMS_PER_PHASE / 2);
            wait_idle();
            run_random(ITEMS_PER_PHASE / 2);
         end else begin
            run_random(ITEMS_PER_PHASE);
         end
      end

      wait_idle();
      repeat (20) @(posedge clock);
      $display("%0d samples sent, %0d results checked under %0d register settings",
               sent, sb.checked, settings_used);
      $display("chatter flag high in %0d results, event count ended at %0d",
               sb.flagged, sb.tally);
      if (sb.mismatches == 0 && sb.expected_q.size() == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end

endmodule
